[rtl/mgpio_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mgpio_pkg
// Shared widths, codes and payload types for the masked GPIO buffer.
// ----------------------------------------------------------------------------
package mgpio_pkg;

	localparam int NUM_OUTPUTS  = 20;
	localparam int NUM_INPUTS   = 12;
	localparam int NUM_SWITCHES = 8;

	localparam int CFG_DATA_W  = 20;
	localparam int CFG_INDEX_W = 3;

	// action codes; code 3 is a no-op
	localparam logic [1:0] ACT_SCAN   = 2'd0;
	localparam logic [1:0] ACT_WRITE  = 2'd1;
	localparam logic [1:0] ACT_REPORT = 2'd2;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_OUT_WMASK  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_IN_RMASK   = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_SW_ENMASK  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_IN_INVERT  = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_OUT_INVERT = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_SW_INVERT  = 3'd5;

	localparam logic [NUM_OUTPUTS-1:0] OUT_INVERT_RESET = 20'hE0000;

	typedef struct packed {
		logic [1:0]              action;
		logic [7:0]              pin_id;
		logic [7:0]              bit_value;
		logic [NUM_INPUTS-1:0]   input_pins;
		logic [NUM_SWITCHES-1:0] switch_pins;
	} in_item_t;

	typedef struct packed {
		logic [NUM_OUTPUTS-1:0]  output_pins;
		logic                    input_report;
		logic [NUM_INPUTS-1:0]   input_word;
		logic                    switch_report;
		logic [NUM_SWITCHES-1:0] switch_word;
		logic [NUM_INPUTS-1:0]   input_masked;
		logic [NUM_SWITCHES-1:0] switch_masked;
	} out_item_t;

	typedef struct packed {
		logic [NUM_OUTPUTS-1:0]  output_write_mask;
		logic [NUM_INPUTS-1:0]   input_read_mask;
		logic [NUM_SWITCHES-1:0] switch_enable_mask;
		logic [NUM_INPUTS-1:0]   input_invert;
		logic [NUM_OUTPUTS-1:0]  output_invert;
		logic [NUM_SWITCHES-1:0] switch_invert;
	} cfg_t;

	typedef struct packed {
		logic [NUM_OUTPUTS-1:0]  out_buf;
		logic [NUM_OUTPUTS-1:0]  driven_levels;
		logic [NUM_INPUTS-1:0]   input_store;
		logic [NUM_SWITCHES-1:0] switch_store;
	} gpio_state_t;

endpackage
`default_nettype wire

[rtl/masked_gpio_buffer_with_change_report.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// masked_gpio_buffer_with_change_report
// GPIO block: masked output buffer, inverted input sampling, switch reports.
// ----------------------------------------------------------------------------
// Each transfer on the input channel is one action (scan, output bit write,
// forced input report or no-op) and produces exactly one result transfer.
// The block takes one transfer per clock while the output side is not
// stalled: an item lands in the input register, the step logic works it
// against the stored state and the result is loaded into the output register.
// The output register and input register form a two-deep path, so a new
// transfer is taken while a finished result still waits on out_ready.
// Configuration writes (cfg_we/cfg_index/cfg_data) take effect on the next
// edge and must be issued only while no action is in flight; unknown indexes
// are dropped.
// ----------------------------------------------------------------------------
module masked_gpio_buffer_with_change_report import mgpio_pkg::*; (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    cfg_we,
	input  wire [CFG_INDEX_W-1:0]  cfg_index,
	input  wire [CFG_DATA_W-1:0]   cfg_data,
	input  wire                    in_valid,
	output logic                   in_ready,
	input  wire in_item_t          in_data,
	output logic                   out_valid,
	input  wire                    out_ready,
	output out_item_t              out_data
);

	cfg_t        cfg_q;
	gpio_state_t state_q;
	gpio_state_t state_nxt;
	in_item_t    item_s1;
	logic        valid_s1;
	out_item_t   result;
	logic        advance;

	// Stage 1 moves into the result register when that register is free
	// or being drained this cycle.
	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.output_write_mask  <= '1;
			cfg_q.input_read_mask    <= '1;
			cfg_q.switch_enable_mask <= '1;
			cfg_q.input_invert       <= '1;
			cfg_q.output_invert      <= OUT_INVERT_RESET;
			cfg_q.switch_invert      <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_OUT_WMASK:  cfg_q.output_write_mask  <= cfg_data[NUM_OUTPUTS-1:0];
				CFG_IN_RMASK:   cfg_q.input_read_mask    <= cfg_data[NUM_INPUTS-1:0];
				CFG_SW_ENMASK:  cfg_q.switch_enable_mask <= cfg_data[NUM_SWITCHES-1:0];
				CFG_IN_INVERT:  cfg_q.input_invert       <= cfg_data[NUM_INPUTS-1:0];
				CFG_OUT_INVERT: cfg_q.output_invert      <= cfg_data[NUM_OUTPUTS-1:0];
				CFG_SW_INVERT:  cfg_q.switch_invert      <= cfg_data[NUM_SWITCHES-1:0];
				default: begin
				end
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	mgpio_step u_step (
		.item   (item_s1),
		.cfg    (cfg_q),
		.cur    (state_q),
		.nxt    (state_nxt),
		.result (result)
	);

	// GPIO state commits only when the item's result is captured
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.out_buf       <= '0;
			state_q.driven_levels <= OUT_INVERT_RESET;
			state_q.input_store   <= '0;
			state_q.switch_store  <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data <= result;
		end
	end

endmodule
`default_nettype wire

[rtl/mgpio_step.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mgpio_step
// Next-state and result logic for one action against the current GPIO state.
// ----------------------------------------------------------------------------
module mgpio_step import mgpio_pkg::*; (
	input  wire in_item_t    item,
	input  wire cfg_t        cfg,
	input  wire gpio_state_t cur,
	output gpio_state_t      nxt,
	output out_item_t        result
);

	logic [NUM_INPUTS-1:0]   in_word;
	logic [NUM_SWITCHES-1:0] sw_word;
	logic [NUM_OUTPUTS-1:0]  wr_bit;
	logic                    in_rep;
	logic                    sw_rep;

	always_comb begin
		in_word = (item.input_pins ^ cfg.input_invert);
		sw_word = ~(item.switch_pins ^ cfg.switch_invert);
		wr_bit  = (NUM_OUTPUTS'(1) << item.pin_id) & cfg.output_write_mask;
		nxt     = cur;
		in_rep  = 1'b0;
		sw_rep  = 1'b0;
		case (item.action)
			ACT_SCAN: begin
				in_rep = (in_word != cur.input_store);
				nxt.input_store = in_word;
				nxt.driven_levels = (cur.driven_levels & ~cfg.output_write_mask)
					| ((cur.out_buf ^ cfg.output_invert) & cfg.output_write_mask);
				// switches only move while the enable mask is fully open
				if (&cfg.switch_enable_mask) begin
					sw_rep = (sw_word != cur.switch_store);
					nxt.switch_store = sw_word;
				end
			end
			ACT_WRITE: begin
				if (item.pin_id < 8'(NUM_OUTPUTS)) begin
					if (item.bit_value == 8'd0) begin
						nxt.out_buf = cur.out_buf & ~wr_bit;
					end else begin
						nxt.out_buf = cur.out_buf | wr_bit;
					end
				end
			end
			ACT_REPORT: begin
				nxt.input_store = in_word;
				in_rep = 1'b1;
			end
			default: begin
			end
		endcase

		result.output_pins   = nxt.driven_levels;
		result.input_report  = in_rep;
		result.input_word    = nxt.input_store;
		result.switch_report = sw_rep;
		result.switch_word   = nxt.switch_store;
		result.input_masked  = nxt.input_store & cfg.input_read_mask;
		result.switch_masked = nxt.switch_store & cfg.switch_enable_mask;
	end

endmodule
`default_nettype wire

[verif/tb_masked_gpio_buffer_with_change_report.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_masked_gpio_buffer_with_change_report
// Self-checking bench for the masked GPIO buffer with change reports.
// ----------------------------------------------------------------------------
// Random and directed scan, write and forced-report actions are driven through
// the valid/ready input channel under several register settings. A mirror of
// the GPIO state predicts one result per accepted action and every result
// transfer is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_masked_gpio_buffer_with_change_report;
	import mgpio_pkg::*;

	// unused action code, must behave as a no-op
	localparam logic [1:0] ACT_NONE = 2'd3;

	// slack for the pipe to settle after the last predicted result has arrived
	localparam int DRAIN_CYCLES = 6;
	localparam int HOLD_CYCLES  = 64;
	localparam int PHASE_ITEMS  = 300;
	localparam int MAX_PRINTS   = 50;

	// ------------------------------------------------------------------------
	// Mirror of the GPIO state plus the queue of predicted results
	// ------------------------------------------------------------------------
	class gpio_result_board;
		cfg_t        regs;
		gpio_state_t mirror;
		out_item_t   pending_results[$];
		int          errors;
		int          checked;
		int          in_reports;
		int          sw_reports;
		int          by_action[4];

		function new();
			regs = '{output_write_mask: '1, input_read_mask: '1, switch_enable_mask: '1,
				input_invert: '1, output_invert: OUT_INVERT_RESET, switch_invert: '0};
			mirror = '{out_buf: '0, driven_levels: OUT_INVERT_RESET,
				input_store: '0, switch_store: '0};
			errors = 0;
			checked = 0;
			in_reports = 0;
			sw_reports = 0;
			by_action = '{default: 0};
		endfunction

		// unknown indexes fall through and change nothing
		function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
			case (idx)
			CFG_OUT_WMASK:  regs.output_write_mask  = d[NUM_OUTPUTS-1:0];
			CFG_IN_RMASK:   regs.input_read_mask    = d[NUM_INPUTS-1:0];
			CFG_SW_ENMASK:  regs.switch_enable_mask = d[NUM_SWITCHES-1:0];
			CFG_IN_INVERT:  regs.input_invert       = d[NUM_INPUTS-1:0];
			CFG_OUT_INVERT: regs.output_invert      = d[NUM_OUTPUTS-1:0];
			CFG_SW_INVERT:  regs.switch_invert      = d[NUM_SWITCHES-1:0];
			default: ;
			endcase
		endfunction

		// accepted input transfer: step the mirror, queue the result it causes
		function void note_action(in_item_t a);
			out_item_t                r;
			logic [NUM_INPUTS-1:0]   word;
			logic [NUM_SWITCHES-1:0] sw;
			logic [NUM_OUTPUTS-1:0]  sel;
			r = '0;
			by_action[a.action]++;
			case (a.action)
			ACT_SCAN: begin
				word = a.input_pins ^ regs.input_invert;
				r.input_report = (word != mirror.input_store);
				mirror.input_store = word;
				// masked pins hold their last level
				mirror.driven_levels = (mirror.driven_levels & ~regs.output_write_mask) |
					((mirror.out_buf ^ regs.output_invert) & regs.output_write_mask);
				// switches only move with the full enable mask
				if (&regs.switch_enable_mask) begin
					sw = ~(a.switch_pins ^ regs.switch_invert);
					if (sw != mirror.switch_store) begin
						mirror.switch_store = sw;
						r.switch_report = 1'b1;
					end
				end
			end
			ACT_WRITE: begin
				// buffer only; pins follow at the next scan
				if (a.pin_id < NUM_OUTPUTS) begin
					sel = '0;
					sel[a.pin_id] = 1'b1;
					sel &= regs.output_write_mask;
					if (a.bit_value == '0)
						mirror.out_buf &= ~sel;
					else
						mirror.out_buf |= sel;
				end
			end
			ACT_REPORT: begin
				mirror.input_store = a.input_pins ^ regs.input_invert;
				r.input_report = 1'b1;
			end
			default: ;
			endcase
			r.output_pins   = mirror.driven_levels;
			r.input_word    = mirror.input_store;
			r.switch_word   = mirror.switch_store;
			r.input_masked  = mirror.input_store & regs.input_read_mask;
			r.switch_masked = mirror.switch_store & regs.switch_enable_mask;
			pending_results.push_back(r);
		endfunction

		function void check_field(string name, logic [NUM_OUTPUTS-1:0] want,
				logic [NUM_OUTPUTS-1:0] seen);
			if (seen !== want) begin
				errors++;
				if (errors <= MAX_PRINTS)
					$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, seen);
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= MAX_PRINTS)
					$display("%0t: result with nothing expected, expected none, got %h",
						$time, got);
				return;
			end
			want = pending_results.pop_front();
			check_field("output_pins",   want.output_pins,   got.output_pins);
			check_field("input_report",  want.input_report,  got.input_report);
			check_field("input_word",    want.input_word,    got.input_word);
			check_field("switch_report", want.switch_report, got.switch_report);
			check_field("switch_word",   want.switch_word,   got.switch_word);
			check_field("input_masked",  want.input_masked,  got.input_masked);
			check_field("switch_masked", want.switch_masked, got.switch_masked);
			checked++;
			in_reports += want.input_report;
			sw_reports += want.switch_report;
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// DUT hookup
	// ------------------------------------------------------------------------
	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   in_valid;
	logic                   in_ready;
	in_item_t               in_data;
	logic                   out_valid;
	logic                   out_ready;
	out_item_t              out_data;

	gpio_result_board board = new();

	// steady: neither side idles; hold_out: receiver stalls for a long stretch
	bit                      steady;
	bit                      hold_out;
	logic [NUM_INPUTS-1:0]   last_in_pins;
	logic [NUM_SWITCHES-1:0] last_sw_pins;
	int                      settings_used;

	masked_gpio_buffer_with_change_report u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Global watchdog, far beyond the slowest legal run.
	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Sampling at the rising edge: input transfers feed the mirror before the
	// same edge's result transfer is checked (a result lags its input anyway).
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				board.note_action(in_data);
			if (out_valid && out_ready)
				board.check_result(out_data);
		end
	end

	// ------------------------------------------------------------------------
	// Result side: random back-pressure, a steady mode and one long hold-off
	// counted here so the input side keeps pushing into a full block.
	// ------------------------------------------------------------------------
	initial begin
		int hold_cnt;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_out) begin
				out_ready <= 1'b0;
				for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++)
					@(negedge clk);
				hold_out = 1'b0;
				out_ready <= 1'b1;
			end else if (steady) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= 17);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------------
	// One input transfer; random idle cycles ahead of it unless steady.
	task automatic send_item(input in_item_t it);
		while (!steady && $urandom_range(99) < 17) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Drop valid, wait for every predicted result, then let the pipe settle.
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (board.pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Writes all six registers (junk in the unused upper data bits) plus the
	// two unused indexes, which must be dropped. Only called while idle.
	task automatic apply_config(input cfg_t c);
		logic [CFG_DATA_W-1:0] vals [8];
		int                    idx;
		for (idx = 0; idx < 8; idx++)
			vals[idx] = CFG_DATA_W'($urandom);
		vals[CFG_OUT_WMASK]                      = c.output_write_mask;
		vals[CFG_IN_RMASK][NUM_INPUTS-1:0]       = c.input_read_mask;
		vals[CFG_SW_ENMASK][NUM_SWITCHES-1:0]    = c.switch_enable_mask;
		vals[CFG_IN_INVERT][NUM_INPUTS-1:0]      = c.input_invert;
		vals[CFG_OUT_INVERT]                     = c.output_invert;
		vals[CFG_SW_INVERT][NUM_SWITCHES-1:0]    = c.switch_invert;
		for (idx = 0; idx < 8; idx++) begin
			@(negedge clk);
			cfg_we    <= 1'b1;
			cfg_index <= CFG_INDEX_W'(idx);
			cfg_data  <= vals[idx];
			@(posedge clk);
			board.write_reg(CFG_INDEX_W'(idx), vals[idx]);
		end
		@(negedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	function automatic in_item_t make_item(logic [1:0] act, logic [7:0] id,
			logic [7:0] val, logic [NUM_INPUTS-1:0] ip, logic [NUM_SWITCHES-1:0] sp);
		in_item_t it;
		it.action      = act;
		it.pin_id      = id;
		it.bit_value   = val;
		it.input_pins  = ip;
		it.switch_pins = sp;
		return it;
	endfunction

	function automatic cfg_t random_cfg(bit full_switch_en);
		cfg_t c;
		c.output_write_mask  = NUM_OUTPUTS'($urandom);
		c.input_read_mask    = NUM_INPUTS'($urandom);
		c.switch_enable_mask = full_switch_en ? '1 : NUM_SWITCHES'($urandom);
		c.input_invert       = NUM_INPUTS'($urandom);
		c.output_invert      = NUM_OUTPUTS'($urandom);
		c.switch_invert      = NUM_SWITCHES'($urandom);
		return c;
	endfunction

	// Mostly well-formed actions: writes to real pins, and pin words that often
	// repeat or move by one bit so both "changed" and "unchanged" come up.
	function automatic in_item_t random_item();
		in_item_t it;
		int       r;
		r = $urandom_range(99);
		it.action = (r < 40) ? ACT_SCAN : (r < 75) ? ACT_WRITE : (r < 95) ? ACT_REPORT : ACT_NONE;
		it.pin_id = ($urandom_range(99) < 80) ? 8'($urandom_range(NUM_OUTPUTS - 1))
			: 8'($urandom_range(255, NUM_OUTPUTS));
		it.bit_value = ($urandom_range(99) < 35) ? 8'd0 : 8'($urandom_range(255, 1));
		r = $urandom_range(99);
		if (r < 45)
			it.input_pins = last_in_pins;
		else if (r < 70)
			it.input_pins = last_in_pins ^ (NUM_INPUTS'(1) << $urandom_range(NUM_INPUTS - 1));
		else
			it.input_pins = NUM_INPUTS'($urandom);
		r = $urandom_range(99);
		if (r < 45)
			it.switch_pins = last_sw_pins;
		else if (r < 70)
			it.switch_pins = last_sw_pins ^
				(NUM_SWITCHES'(1) << $urandom_range(NUM_SWITCHES - 1));
		else
			it.switch_pins = NUM_SWITCHES'($urandom);
		last_in_pins = it.input_pins;
		last_sw_pins = it.switch_pins;
		return it;
	endfunction

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		cfg_t c;
		int   phase;
		int   n;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		in_valid      = 1'b0;
		in_data       = '0;
		steady        = 1'b0;
		hold_out      = 1'b0;
		last_in_pins  = '0;
		last_sw_pins  = '0;
		settings_used = 1;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed, reset register values. First scan flips both stored words.
		send_item(make_item(ACT_SCAN,   8'd0,   8'd0,   12'h000, 8'h00));
		send_item(make_item(ACT_SCAN,   8'd0,   8'd0,   12'h000, 8'h00)); // no change
		send_item(make_item(ACT_WRITE,  8'd0,   8'd1,   12'h000, 8'h00));
		send_item(make_item(ACT_WRITE,  8'd19,  8'hFF,  12'h000, 8'h00)); // top pin
		send_item(make_item(ACT_WRITE,  8'd20,  8'd1,   12'hFFF, 8'hFF)); // out of range
		send_item(make_item(ACT_WRITE,  8'd255, 8'hFF,  12'hFFF, 8'hFF)); // out of range
		send_item(make_item(ACT_WRITE,  8'd10,  8'h80,  12'h000, 8'h00));
		send_item(make_item(ACT_WRITE,  8'd10,  8'd0,   12'h000, 8'h00)); // clear again
		send_item(make_item(ACT_WRITE,  8'd7,   8'd1,   12'h000, 8'h00));
		send_item(make_item(ACT_SCAN,   8'd0,   8'd0,   12'hFFF, 8'hFF)); // pins follow
		send_item(make_item(ACT_REPORT, 8'd0,   8'd0,   12'hFFF, 8'h00)); // same word
		send_item(make_item(ACT_REPORT, 8'd0,   8'd0,   12'hA5A, 8'h3C));
		send_item(make_item(ACT_NONE,   8'd3,   8'd1,   12'h5A5, 8'hC3)); // no-op
		wait_drained();

		// Directed, partial masks: masked write, held pins, frozen switches.
		c = '{output_write_mask: 20'h0FFFF, input_read_mask: 12'hF0F,
			switch_enable_mask: 8'h7F, input_invert: 12'h000,
			output_invert: 20'hFFFFF, switch_invert: 8'hFF};
		apply_config(c);
		send_item(make_item(ACT_WRITE,  8'd17,  8'd1,   12'h000, 8'h00)); // masked bit
		send_item(make_item(ACT_WRITE,  8'd3,   8'd1,   12'h000, 8'h00));
		send_item(make_item(ACT_SCAN,   8'd0,   8'd0,   12'h123, 8'h55));
		send_item(make_item(ACT_SCAN,   8'd0,   8'd0,   12'h123, 8'hAA));
		send_item(make_item(ACT_REPORT, 8'd0,   8'd0,   12'hFFF, 8'hFF));
		send_item(make_item(ACT_NONE,   8'd0,   8'd0,   12'h000, 8'h00));
		wait_drained();

		// Random phases: all ones, all zeros, then random settings. Phase 4
		// runs with no idling on either side; phase 5 holds the result side
		// off while items keep coming, so the block fills and stalls.
		for (phase = 0; phase < 6; phase++) begin
			case (phase)
			0:       c = '1;
			1:       c = '0;
			3:       c = random_cfg(1'b0);
			default: c = random_cfg(1'b1);
			endcase
			apply_config(c);
			steady = (phase == 4);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (phase == 5 && n == 100) begin
					hold_out = 1'b1;
					steady   = 1'b1;
				end
				if (phase == 5 && n == 140)
					steady = 1'b0;
				send_item(random_item());
			end
			steady = 1'b0;
			wait_drained();
		end

		$display("Ran %0d scans, %0d writes, %0d forced reports and %0d no-ops over %0d settings",
			board.by_action[ACT_SCAN], board.by_action[ACT_WRITE],
			board.by_action[ACT_REPORT], board.by_action[ACT_NONE], settings_used);
		$display("Checked %0d results: %0d input reports, %0d switch reports, %0d mismatches",
			board.checked, board.in_reports, board.sw_reports, board.errors);
		if (board.errors == 0 && board.pending_results.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
